### rtl/lz77d_pkg.sv
// Package with the phase and status codes, length constants and history request of the LZ77 token stream decoder.
package lz77d_pkg;

  typedef enum logic [3:0] {
    PH_TOKEN = 4'd0,
    PH_OFF0  = 4'd1,
    PH_OFFX  = 4'd2,
    PH_LLEN0 = 4'd3,
    PH_LLENX = 4'd4,
    PH_LIT   = 4'd5,
    PH_MLEN0 = 4'd6,
    PH_MLENX = 4'd7,
    PH_END   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_CORRUPT  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_END      = 3'd5
  } status_e;

  localparam logic [7:0] ExtBase = 8'd252;
  localparam logic [7:0] ExtBias = 8'd251;
  localparam logic [31:0] LenBias = 32'd15;

  // One history write and read request, issued by the decoder to the window memory.
  typedef struct packed {
    logic        we;
    logic [31:0] waddr;
    logic [7:0]  wdata;
    logic        re;
    logic [31:0] raddr;
  } hist_req_t;

endpackage

### rtl/lz77d_window.sv
// History window: one-write, one-read synchronous byte memory.
module lz77d_window #(
  parameter int unsigned WindowBytes = 65536
) (
  input  logic                clk_i,
  input  lz77d_pkg::hist_req_t req_i,
  output logic [7:0]          rdata_o
);
  import lz77d_pkg::*;

  localparam int unsigned AddrW = (WindowBytes > 1) ? $clog2(WindowBytes) : 1;

  logic [7:0] mem [WindowBytes];
  logic [AddrW-1:0] waddr, raddr;

  // Window depth need not be a power of two; callers give an address below it.
  assign waddr = req_i.waddr[AddrW-1:0];
  assign raddr = req_i.raddr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[raddr];
    end
  end

endmodule

### rtl/lz77_token_stream_decoder.sv
// Top level of the LZ77 token stream decoder: parser, copy engine and output register.
//
//   channel   signals                                    direction
//   input     in_valid_i/in_ready_o, req_type/in_byte/in_last   in
//   output    out_valid_o/out_ready_i, out_* / status_o / copy_pending_o  out
//   config    cfg_we_i, cfg_wdata_i                       in
//
// One item per cycle while the output is not stalled. A copy tick uses the byte
// read ahead from the window at a prefetch address kept for the next copy byte; a byte written in the same
// cycle is forwarded, so overlapping copies run at full rate.
// Reset clears all control state; the window is not cleared.
// A stall on the output holds the output register and lowers in_ready_o.
module lz77_token_stream_decoder #(
  parameter int unsigned WINDOW_BYTES  = 65536,
  parameter int unsigned MIN_MATCH_LEN = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_out_valid_o,
  output logic [2:0]  status_o,
  output logic        copy_pending_o
);
  import lz77d_pkg::*;

  localparam logic [32:0] Win = 33'(WINDOW_BYTES);
  localparam logic [31:0] MinM = 32'(MIN_MATCH_LEN);

  logic [31:0] limit_q;
  logic [31:0] prod_q, prod_d;
  phase_e      ph_q, ph_d;
  logic [7:0]  tok_q, tok_d;
  logic [31:0] off_q, off_d, len_q, len_d, rem_q, rem_d, dist_q, dist_d;
  logic [2:0]  left_q, left_d, fsz_q, fsz_d;
  status_e     sticky_q, sticky_d;
  logic [31:0] rd_q, rd_d;      // window index of the next copy byte
  logic [31:0] wp_q, wp_d;      // window index of the next write
  logic        fwd_q, fwd_d;
  logic [7:0]  fwdb_q, fwdb_d;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic [2:0]  st_q;
  logic        cp_q;

  hist_req_t   hreq;
  logic [7:0]  rdata, cbyte;
  logic        take;
  logic [7:0]  ob;
  logic        ov;
  status_e     st;

  lz77d_window #(.WindowBytes(WINDOW_BYTES)) u_win (
    .clk_i  (clk_i),
    .req_i  (hreq),
    .rdata_o(rdata)
  );

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign cbyte = fwd_q ? fwdb_q : rdata;

  function automatic logic [31:0] wrap_inc(input logic [31:0] a);
    logic [32:0] n;
    n = {1'b0, a} + 33'd1;
    return (n >= Win) ? 32'd0 : n[31:0];
  endfunction

  // Main decode step, following the byte-level state machine.
  always_comb begin
    logic        fit_ok;
    logic [32:0] need;
    logic [31:0] n;
    logic [32:0] sum;
    logic        lit;
    logic        do_start, do_begin, do_after, do_fin_len;
    logic [2:0]  pos;
    logic [32:0] src;
    ph_d = ph_q; tok_d = tok_q; off_d = off_q; len_d = len_q; rem_d = rem_q;
    dist_d = dist_q; left_d = left_q; fsz_d = fsz_q; sticky_d = sticky_q;
    prod_d = prod_q; rd_d = rd_q; wp_d = wp_q;
    fwd_d = 1'b0; fwdb_d = fwdb_q;
    hreq = '0; ob = 8'd0; ov = 1'b0; st = sticky_q;
    n = 32'd0; sum = '0; lit = 1'b0; pos = '0; src = '0;
    do_start = 1'b0; do_begin = 1'b0; do_after = 1'b0; do_fin_len = 1'b0;
    need = '0; fit_ok = 1'b0;
    if (take && sticky_q == ST_OK) begin
      if (req_type_i) begin
        if (rem_q != 32'd0) begin
          ob = cbyte; ov = 1'b1;
          rem_d = rem_q - 32'd1;
        end
      end else if (rem_q != 32'd0) begin
        st = ST_BUSY;
      end else begin
        case (ph_q)
          PH_TOKEN: begin
            tok_d = in_byte_i; ph_d = PH_OFF0;
          end
          PH_OFF0: begin
            if (in_byte_i[3:0] == 4'd0) begin
              sticky_d = ST_CORRUPT;
            end else begin
              fsz_d = in_byte_i[0] ? 3'd1 : in_byte_i[1] ? 3'd2 : in_byte_i[2] ? 3'd3 : 3'd4;
              off_d = {24'd0, in_byte_i};
              left_d = fsz_d - 3'd1;
              if (fsz_d == 3'd1) begin
                off_d = off_d >> 1;
                if (tok_q[7:4] == 4'hF) ph_d = PH_LLEN0;
                else begin do_begin = 1'b1; n = {28'd0, tok_q[7:4]}; end
              end else ph_d = PH_OFFX;
            end
          end
          PH_OFFX: begin
            pos = (fsz_q - left_q) & 3'd3;
            off_d = off_q | ({24'd0, in_byte_i} << (5'd8 * 5'(pos)));
            left_d = left_q - 3'd1;
            if (left_d == 3'd0) begin
              off_d = off_d >> fsz_q;
              if (tok_q[7:4] == 4'hF) ph_d = PH_LLEN0;
              else begin do_begin = 1'b1; n = {28'd0, tok_q[7:4]}; end
            end
          end
          PH_LLEN0, PH_MLEN0: begin
            lit = (ph_q == PH_LLEN0);
            if (in_byte_i < ExtBase) begin
              do_fin_len = 1'b1; sum = {25'd0, in_byte_i};
            end else begin
              fsz_d = 3'(in_byte_i - ExtBias);
              left_d = fsz_d; len_d = 32'd0;
              ph_d = lit ? PH_LLENX : PH_MLENX;
            end
          end
          PH_LLENX, PH_MLENX: begin
            lit = (ph_q == PH_LLENX);
            pos = (fsz_q - left_q) & 3'd3;
            len_d = len_q | ({24'd0, in_byte_i} << (5'd8 * 5'(pos)));
            left_d = left_q - 3'd1;
            if (left_d == 3'd0) begin
              do_fin_len = 1'b1;
              sum = 33'(ExtBias) + 33'(fsz_q) + {1'b0, len_d};
            end
          end
          PH_LIT: begin
            ob = in_byte_i; ov = 1'b1;
            len_d = len_q - 32'd1;
            if (len_d == 32'd0) do_after = 1'b1;
          end
          default: ;
        endcase
        if (do_fin_len) begin
          sum = sum + 33'(LenBias) + (lit ? 33'd0 : 33'(MinM));
          n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (lit) do_begin = 1'b1; else do_start = 1'b1;
        end
        if (do_begin) begin
          need = {1'b0, prod_q} + {1'b0, n};
          if (need > {1'b0, limit_q}) sticky_d = ST_OVERFLOW;
          else if (n == 32'd0) do_after = 1'b1;
          else begin len_d = n; ph_d = PH_LIT; end
        end
        if (do_after) begin
          // Produced count here includes a literal emitted in this cycle.
          if (off_d > prod_q + {31'd0, ov} || {1'b0, off_d} > Win) sticky_d = ST_CORRUPT;
          else if (off_d == 32'd0) begin sticky_d = ST_END; ph_d = PH_END; end
          else if (tok_q[3:0] == 4'hF) ph_d = PH_MLEN0;
          else begin do_start = 1'b1; n = {28'd0, tok_q[3:0]} + MinM; end
        end
        if (do_start) begin
          // A literal written in this cycle counts toward the limit and the source.
          need = {1'b0, prod_q} + {32'd0, ov} + {1'b0, n};
          if (need > {1'b0, limit_q}) sticky_d = ST_OVERFLOW;
          else begin
            rem_d = n; dist_d = off_d; ph_d = PH_TOKEN;
            src = {1'b0, wp_q} + {32'd0, ov} + Win - {1'b0, off_d};
            if (src >= Win) src = src - Win;
            rd_d = src[31:0];
          end
        end
        if (in_last_i && sticky_d == ST_OK) sticky_d = ST_TRUNC;
        if (sticky_d != ST_OK) rem_d = 32'd0;
        st = sticky_d;
      end
    end
    if (ov) begin
      hreq.we = 1'b1; hreq.waddr = wp_q; hreq.wdata = ob;
      prod_d = prod_q + 32'd1;
      wp_d = wrap_inc(wp_q);
      if (req_type_i) rd_d = wrap_inc(rd_q);
    end
    // Prefetch the next copy byte; forward it when it is written this cycle.
    hreq.re = 1'b1; hreq.raddr = rd_d;
    if (hreq.we && hreq.waddr == rd_d) begin
      fwd_d = 1'b1; fwdb_d = ob;
    end
    if (!take) fwd_d = fwd_q && !(hreq.we);
    if (!take) hreq.re = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 32'hFFFF_FFFF; prod_q <= '0; ph_q <= PH_TOKEN; tok_q <= '0;
      off_q <= '0; len_q <= '0; rem_q <= '0; dist_q <= '0; left_q <= '0;
      fsz_q <= '0; sticky_q <= ST_OK; rd_q <= '0; wp_q <= '0;
      fwd_q <= 1'b0; fwdb_q <= '0; out_valid_o <= 1'b0;
      ov_q <= 1'b0; ob_q <= '0; st_q <= '0; cp_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      prod_q <= prod_d; ph_q <= ph_d; tok_q <= tok_d; off_q <= off_d;
      len_q <= len_d; rem_q <= rem_d; dist_q <= dist_d; left_q <= left_d;
      fsz_q <= fsz_d; sticky_q <= sticky_d; rd_q <= rd_d; wp_q <= wp_d;
      fwd_q <= fwd_d; fwdb_q <= fwdb_d;
      if (take) begin
        out_valid_o <= 1'b1; ov_q <= ov; ob_q <= ob; st_q <= st;
        cp_q <= (rem_d != 32'd0);
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign out_byte_o      = ob_q;
  assign out_out_valid_o = ov_q;
  assign status_o        = st_q;
  assign copy_pending_o  = cp_q;

`ifndef SYNTHESIS
  a_no_out_when_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && sticky_q != ST_OK |-> !ov) else $error("byte emitted after error");
  a_pending_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> cp_q == (rem_q != 32'd0)) else $error("copy_pending mismatch");
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ov |=> prod_q == $past(prod_q) + 32'd1) else $error("count slip");
  a_err_clears_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q != ST_OK |-> rem_q == 32'd0) else $error("copy kept after error");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the LZ77 token stream decoder.
`timescale 1ns / 1ps

module testbench;
  import lz77d_pkg::*;

  typedef enum logic [1:0] {ACT_DATA, ACT_CFG, ACT_DRAIN} act_e;

  typedef struct {
    act_e        kind;
    logic        req;
    logic [7:0]  b;
    logic        last;
    logic [31:0] val;
  } stim_t;

  typedef struct {
    logic [7:0] b;
    logic       ov;
    logic [2:0] st;
    logic       pend;
  } decoded_t;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam int unsigned TARGET_ITEMS = 1350;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_out_valid_o;
  logic [2:0]  status_o;
  logic        copy_pending_o;

  lz77_token_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_out_valid_o(out_out_valid_o),
    .status_o       (status_o),
    .copy_pending_o (copy_pending_o)
  );

  always #6 clk_i = ~clk_i;

  stim_t    pending_stim[$];
  decoded_t decoded_q[$];
  int unsigned mismatches = 0;

  // Decoder shadow state.
  logic [7:0]  win_mem [65536];
  logic [31:0] lim_reg, produced, off_acc, len_acc, cpy_rem, cpy_dist;
  logic [7:0]  tok;
  logic [2:0]  left_cnt, fsize;
  phase_e      phase;
  status_e     sticky;
  logic [7:0]  res_byte;
  logic        res_val;

  function automatic void emit_byte(logic [7:0] b);
    win_mem[produced[15:0]] = b;
    produced = produced + 1;
  endfunction

  function automatic bit room_for(logic [31:0] n);
    return ({1'b0, produced} + {1'b0, n}) <= {1'b0, lim_reg};
  endfunction

  function automatic void raise_error(status_e code);
    sticky = code;
    cpy_rem = '0;
  endfunction

  function automatic void start_copy(logic [31:0] n);
    if (!room_for(n)) begin
      raise_error(ST_OVERFLOW);
      return;
    end
    cpy_rem = n;
    cpy_dist = off_acc;
    phase = PH_TOKEN;
  endfunction

  function automatic void literals_done();
    if (off_acc > produced || off_acc > 32'd65536) begin
      raise_error(ST_CORRUPT);
      return;
    end
    if (off_acc == 0) begin
      sticky = ST_END;
      phase = PH_END;
      return;
    end
    if (tok[3:0] == 4'hF) phase = PH_MLEN0;
    else start_copy(32'(tok[3:0]) + 32'd4);
  endfunction

  function automatic void open_literals(logic [31:0] n);
    if (!room_for(n)) begin
      raise_error(ST_OVERFLOW);
      return;
    end
    if (n == 0) begin
      literals_done();
      return;
    end
    len_acc = n;
    phase = PH_LIT;
  endfunction

  function automatic void close_length(logic [39:0] v, bit is_lit);
    logic [39:0] s;
    s = v + 40'd15 + (is_lit ? 40'd0 : 40'd4);
    if (s > 40'hFFFF_FFFF) s = 40'hFFFF_FFFF;
    if (is_lit) open_literals(s[31:0]);
    else start_copy(s[31:0]);
  endfunction

  function automatic void close_offset();
    off_acc = off_acc >> fsize;
    if (tok[7:4] == 4'hF) phase = PH_LLEN0;
    else open_literals(32'(tok[7:4]));
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int unsigned pos;
    case (phase)
      PH_TOKEN: begin
        tok = b;
        phase = PH_OFF0;
      end
      PH_OFF0: begin
        if (b[3:0] == 4'h0) raise_error(ST_CORRUPT);
        else begin
          fsize = b[0] ? 3'd1 : b[1] ? 3'd2 : b[2] ? 3'd3 : 3'd4;
          off_acc = 32'(b);
          left_cnt = fsize - 3'd1;
          if (left_cnt == 0) close_offset();
          else phase = PH_OFFX;
        end
      end
      PH_OFFX: begin
        pos = (fsize - left_cnt) & 3;
        off_acc = off_acc | (32'(b) << (8 * pos));
        left_cnt = left_cnt - 3'd1;
        if (left_cnt == 0) close_offset();
      end
      PH_LLEN0, PH_MLEN0: begin
        if (b < ExtBase) close_length(40'(b), phase == PH_LLEN0);
        else begin
          fsize = 3'(b - ExtBias);
          left_cnt = fsize;
          len_acc = '0;
          phase = (phase == PH_LLEN0) ? PH_LLENX : PH_MLENX;
        end
      end
      PH_LLENX, PH_MLENX: begin
        pos = (fsize - left_cnt) & 3;
        len_acc = len_acc | (32'(b) << (8 * pos));
        left_cnt = left_cnt - 3'd1;
        if (left_cnt == 0)
          close_length(40'd251 + 40'(fsize) + 40'(len_acc), phase == PH_LLENX);
      end
      PH_LIT: begin
        emit_byte(b);
        res_byte = b;
        res_val = 1'b1;
        len_acc = len_acc - 1;
        if (len_acc == 0) literals_done();
      end
      default: ;
    endcase
  endfunction

  function automatic void decode_item(stim_t it);
    decoded_t   d;
    status_e    st;
    logic [31:0] src;
    res_byte = '0;
    res_val = 1'b0;
    st = sticky;
    if (sticky == ST_OK) begin
      if (it.req == REQ_TICK) begin
        if (cpy_rem != 0) begin
          src = produced - cpy_dist;
          res_byte = win_mem[src[15:0]];
          res_val = 1'b1;
          emit_byte(res_byte);
          cpy_rem = cpy_rem - 1;
        end
        st = sticky;
      end else if (cpy_rem != 0) begin
        st = ST_BUSY;
      end else begin
        parse_byte(it.b);
        if (it.last && sticky == ST_OK) raise_error(ST_TRUNC);
        st = sticky;
      end
    end
    d.b = res_byte;
    d.ov = res_val;
    d.st = st;
    d.pend = (cpy_rem != 0);
    decoded_q.push_back(d);
  endfunction

  // Stream builder. gen_count counts how many bytes the stream built so far decodes to.
  int unsigned gen_count = 0;
  int unsigned n_items = 0;

  task automatic push_data(logic req, logic [7:0] b, logic last);
    stim_t s;
    s.kind = ACT_DATA;
    s.req = req;
    s.b = b;
    s.last = last;
    s.val = '0;
    pending_stim.push_back(s);
    n_items++;
  endtask

  task automatic push_ctrl(act_e kind, logic [31:0] val);
    stim_t s;
    s.kind = kind;
    s.req = REQ_BYTE;
    s.b = '0;
    s.last = 1'b0;
    s.val = val;
    pending_stim.push_back(s);
  endtask

  task automatic push_ext(int unsigned len);
    int unsigned k, kmin, kmax, v;
    if (len < 252) push_data(REQ_BYTE, 8'(len), 1'b0);
    else begin
      kmin = (len - 252 < 256) ? 1 : (len - 253 < 65536) ? 2 : 3;
      // A field of k bytes cannot encode a length below 251 + k.
      kmax = (len - 251 < 4) ? len - 251 : 4;
      k = $urandom_range(kmin, kmax);
      v = len - 251 - k;
      push_data(REQ_BYTE, 8'(251 + k), 1'b0);
      for (int i = 0; i < k; i++) push_data(REQ_BYTE, 8'(v >> (8 * i)), 1'b0);
    end
  endtask

  // One sequence: token, offset, literals, match. Offset 0 ends the stream.
  // With cut set, the byte that starts the copy carries the last flag.
  task automatic add_seq(int unsigned lit, int unsigned mlen, int unsigned off, bit cut);
    int unsigned smin, s;
    logic [31:0] fv;
    logic [3:0] lnib, mnib;
    lnib = (lit < 15) ? 4'(lit) : 4'hF;
    mnib = (mlen - 4 < 15) ? 4'(mlen - 4) : 4'hF;
    push_data(REQ_BYTE, {lnib, mnib}, 1'b0);
    smin = (off < 128) ? 1 : (off < 16384) ? 2 : (off < 2097152) ? 3 : 4;
    s = $urandom_range(smin, 4);
    fv = (off << s) | (32'd1 << (s - 1));
    for (int i = 0; i < s; i++) push_data(REQ_BYTE, fv[8*i +: 8], 1'b0);
    if (lit >= 15) push_ext(lit - 15);
    for (int i = 0; i < lit; i++) push_data(REQ_BYTE, 8'($urandom), 1'b0);
    gen_count += lit;
    if (off == 0) return;
    if (mlen >= 19) push_ext(mlen - 19);
    if (cut) begin
      pending_stim[pending_stim.size() - 1].last = 1'b1;
      return;
    end
    for (int i = 0; i < mlen; i++) begin
      if ($urandom_range(0, 7) == 0) push_data(REQ_BYTE, 8'($urandom), 1'($urandom));
      push_data(REQ_TICK, 8'($urandom), 1'($urandom));
    end
    gen_count += mlen;
    if ($urandom_range(0, 7) == 0) push_data(REQ_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic add_random_seq();
    int unsigned lit, mlen, hi, off, r;
    r = $urandom_range(0, 99);
    lit = (r < 70) ? $urandom_range(0, 14) : (r < 97) ? $urandom_range(15, 40)
                                                    : $urandom_range(255, 300);
    if (gen_count == 0 && lit == 0) lit = 1;
    r = $urandom_range(0, 99);
    mlen = (r < 75) ? $urandom_range(4, 18) : (r < 98) ? $urandom_range(19, 50)
                                                      : $urandom_range(274, 300);
    hi = gen_count + lit;
    if (hi > 65536) hi = 65536;
    // Half the matches use a short distance, so most of them overlap.
    off = $urandom_range(0, 1) ? $urandom_range(1, (hi < 8) ? hi : 8) : $urandom_range(1, hi);
    add_seq(lit, mlen, off, 1'b0);
  endtask

  // Driver: pending transfers to the input channel, register writes when idle.
  stim_t       drv_item, nxt_item;
  logic        nxt_valid, nxt_we;
  logic [31:0] nxt_wdata;
  int unsigned in_gap = 0, settle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= 1'b0;
      in_byte_i   <= '0;
      in_last_i   <= 1'b0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_we = 1'b0;
      nxt_wdata = cfg_wdata_i;
      nxt_item = drv_item;
      if (in_valid_i && in_ready_o) begin
        decode_item(drv_item);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (decoded_q.size() != 0) settle = 0;
        else if (settle < 16) settle++;
        if (in_gap > 0) in_gap--;
        else if (pending_stim.size() != 0) begin
          if (pending_stim[0].kind == ACT_DATA) begin
            if (pending_stim.size() > 120 && $urandom_range(0, 11) == 0)
              in_gap = $urandom_range(0, 9);
            else begin
              nxt_item = pending_stim.pop_front();
              nxt_valid = 1'b1;
            end
          end else if (settle >= 6) begin
            // The decoder is idle here, so a new limit applies to the next item.
            if (pending_stim[0].kind == ACT_CFG) begin
              nxt_we = 1'b1;
              nxt_wdata = pending_stim[0].val;
              lim_reg = pending_stim[0].val;
            end
            void'(pending_stim.pop_front());
          end
        end
      end
      drv_item = nxt_item;
      in_valid_i  <= nxt_valid;
      req_type_i  <= nxt_item.req;
      in_byte_i   <= nxt_item.b;
      in_last_i   <= nxt_item.last;
      cfg_we_i    <= nxt_we;
      cfg_wdata_i <= nxt_wdata;
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Monitor: output stalls and comparison against the oldest expected result.
  int unsigned out_gap = 0;
  logic        nxt_ready;
  decoded_t    want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) report_mismatch("unexpected transfer", 32'd0, 32'd0);
        else begin
          want = decoded_q.pop_front();
          if (out_byte_o !== want.b)
            report_mismatch("out_byte", 32'(out_byte_o), 32'(want.b));
          if (out_out_valid_o !== want.ov)
            report_mismatch("out_valid", 32'(out_out_valid_o), 32'(want.ov));
          if (status_o !== want.st)
            report_mismatch("status", 32'(status_o), 32'(want.st));
          if (copy_pending_o !== want.pend)
            report_mismatch("copy_pending", 32'(copy_pending_o), 32'(want.pend));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        nxt_ready = 1'b0;
      end else if (pending_stim.size() > 120 && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 9);
        nxt_ready = 1'b0;
      end else nxt_ready = 1'b1;
      out_ready_i <= nxt_ready;
    end
  end

  initial begin
    int unsigned pick, hi;
    lim_reg = 32'hFFFF_FFFF;
    produced = '0;
    phase = PH_TOKEN;
    tok = '0;
    off_acc = '0;
    len_acc = '0;
    left_cnt = '0;
    fsize = '0;
    cpy_rem = '0;
    cpy_dist = '0;
    sticky = ST_OK;

    // Directed part: idle tick, overlapping copy of one byte, empty literal
    // run, and a match that exactly fills the output limit.
    push_data(REQ_TICK, 8'hFF, 1'b1);
    add_seq(1, 4, 1, 1'b0);
    add_seq(0, 5, 1, 1'b0);
    push_ctrl(ACT_CFG, 32'(gen_count + 3 + 19));
    add_seq(3, 19, 2, 1'b0);
    push_ctrl(ACT_CFG, 32'hFFFF_FFFF);

    while (n_items < TARGET_ITEMS) begin
      add_random_seq();
      pick = $urandom_range(0, 39);
      if (pick == 0) push_ctrl(ACT_DRAIN, '0);
      else if (pick == 1) push_ctrl(ACT_CFG, 32'hFFFF_FFFF - $urandom_range(0, 1000));
      else if (pick == 2) push_ctrl(ACT_CFG, 32'(gen_count + $urandom_range(100000, 200000)));
    end
    push_ctrl(ACT_DRAIN, '0);

    // Only one terminal condition fits in a run, since errors stay until reset.
    pick = $urandom_range(0, 4);
    hi = gen_count;
    case (pick)
      0: add_seq($urandom_range(0, 20), 4, 0, 1'b0);
      1: begin
        push_data(REQ_BYTE, 8'($urandom), 1'b0);
        push_data(REQ_BYTE, {4'($urandom), 4'h0}, 1'b0);
      end
      2: add_seq(2, 4, $urandom_range(0, 1) ? hi + 3 : 65537, 1'b0);
      3: begin
        push_ctrl(ACT_CFG, '0);
        add_seq($urandom_range(1, 9), 4, 1, 1'b0);
      end
      default: add_seq($urandom_range(0, 5), $urandom_range(4, 30), 1, 1'b1);
    endcase
    for (int i = 0; i < 5; i++) push_data(1'($urandom), 8'($urandom), 1'($urandom));
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_stim.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
